// ----- src/rls_pkg.sv -----
// Shared types, constants and helpers for the random looping shift register.
// Used by rls_shift_core, rls_seq_scale and random_looping_shift_register.
package rls_pkg;

    localparam int DEF_MAX_LENGTH = 128;
    localparam int DEF_MAX_DELAY  = 32;

    localparam int LEVEL_W     = 12;
    localparam int DRAW_W      = 7;
    localparam int FACTOR_W    = 7;
    localparam int STEPS       = 8;
    localparam int CV_W        = 12;
    localparam int SEQ_W       = 16;
    localparam int SUM_W       = 15;
    localparam int TAPS_W      = 16;
    localparam int LEN_W       = 8;
    localparam int LEN_CMP_W   = 9;
    localparam int TICKS_W     = 6;
    localparam int DLY_CMP_W   = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OR_TRIGGER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AND_TRIGGER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OR_GATE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AND_GATE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODE     = 3'd7;

    localparam logic [1:0] SEQ_OFF    = 2'd0;
    localparam logic [1:0] SEQ_SUM    = 2'd1;
    localparam logic [1:0] SEQ_SCALED = 2'd2;

    localparam logic [LEN_W-1:0]     RESET_LENGTH = 8'd16;
    localparam logic [TICKS_W-1:0]   RESET_TICKS  = 6'd4;
    localparam logic [LEN_CMP_W-1:0] MIN_LENGTH   = 9'd8;

    localparam logic [LEVEL_W-1:0]  BAND_LOW      = 12'd1700;
    localparam logic [LEVEL_W-1:0]  BAND_HIGH     = 12'd1800;
    localparam logic [FACTOR_W-1:0] FACTOR_MID    = 7'd50;
    localparam logic [FACTOR_W-1:0] FACTOR_ALWAYS = 7'd100;

    // level * 50 / 1700 is level / 34, done by a rounded-up reciprocal
    localparam int FACTOR_DIV     = 1700 / 50;
    localparam int FACTOR_SHIFT   = 18;
    localparam int FACTOR_RECIP_W = 13;
    localparam int FACTOR_PROD_W  = LEVEL_W + FACTOR_RECIP_W;
    localparam logic [FACTOR_RECIP_W-1:0] FACTOR_RECIP =
        FACTOR_RECIP_W'(((longint'(1) << FACTOR_SHIFT) + FACTOR_DIV - 1) / FACTOR_DIV);

    // sum * 4096 / 3500 is sum * 1024 / 875; scaled value / 3500 is (p >> 2) / 875
    localparam int SEQ_DIV     = 3500 / 4;
    localparam int Q1_SHIFT    = 25;
    localparam int Q1_RECIP_W  = 26;
    localparam int Q1_PROD_W   = SUM_W + Q1_RECIP_W;
    localparam logic [Q1_RECIP_W-1:0] Q1_RECIP =
        Q1_RECIP_W'(((longint'(1) << (Q1_SHIFT + 10)) + SEQ_DIV - 1) / SEQ_DIV);
    localparam int P_W         = SEQ_W + LEVEL_W;
    localparam int Q2_IN_W     = P_W - 2;
    localparam int Q2_SHIFT    = 36;
    localparam int Q2_RECIP_W  = 27;
    localparam int Q2_PROD_W   = Q2_IN_W + Q2_RECIP_W;
    localparam logic [Q2_RECIP_W-1:0] Q2_RECIP =
        Q2_RECIP_W'(((longint'(1) << Q2_SHIFT) + SEQ_DIV - 1) / SEQ_DIV);

    typedef struct packed {
        logic [LEN_W-1:0]   length_in_use;
        logic               delay_enable;
        logic [TICKS_W-1:0] delay_ticks;
        logic [TAPS_W-1:0]  or_trigger_taps;
        logic [TAPS_W-1:0]  and_trigger_taps;
        logic [TAPS_W-1:0]  or_gate_taps;
        logic [TAPS_W-1:0]  and_gate_taps;
        logic [1:0]         sequencer_mode;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]             control_level;
        logic [DRAW_W-1:0]              random_draw;
        logic [LEVEL_W-1:0]             scale_level;
        logic [STEPS-1:0][LEVEL_W-1:0]  step_level;
    } in_item_t;

    typedef struct packed {
        logic [CV_W-1:0]    cv_value;
        logic [CV_W-1:0]    delayed_cv;
        logic [STEPS-1:0]   step_bits;
        logic               trig_any;
        logic               trig_all;
        logic               gate_any;
        logic               gate_all;
        logic [SUM_W-1:0]   seq_sum;
        logic               seq_en;
        logic               seq_scaled;
        logic [LEVEL_W-1:0] scale_level;
    } stage1_t;

    typedef struct packed {
        logic [CV_W-1:0]  cv_value;
        logic [CV_W-1:0]  delayed_cv;
        logic [STEPS-1:0] step_bits;
        logic             or_trigger_out;
        logic             and_trigger_out;
        logic             or_gate_out;
        logic             and_gate_out;
        logic [SEQ_W-1:0] sequencer_cv;
    } out_item_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctl_t;

    function automatic logic multi_tap(input logic [TAPS_W-1:0] mask);
        return (mask & (mask - 1'b1)) != '0;
    endfunction

endpackage

// ----- src/rls_shift_core.sv -----
// Loop register, flip decision, CV history, tap gates and step sum (stage 1).
// Depends on rls_pkg.
module rls_shift_core #(
    parameter int MAX_LENGTH = rls_pkg::DEF_MAX_LENGTH,
    parameter int MAX_DELAY  = rls_pkg::DEF_MAX_DELAY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rls_pkg::pipe_ctl_t ctl,
    input  rls_pkg::cfg_t      cfg,
    input  rls_pkg::in_item_t  item,
    output rls_pkg::stage1_t   s1
);

    localparam int LIDX_W = $clog2(MAX_LENGTH);
    localparam int HIDX_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int TAP_N  = (MAX_LENGTH < rls_pkg::TAPS_W) ? MAX_LENGTH : rls_pkg::TAPS_W;

    logic [MAX_LENGTH-1:0]          loop_reg;
    logic [MAX_LENGTH-1:0]          loop_next;
    logic [rls_pkg::CV_W-1:0]       hist_reg  [MAX_DELAY];
    logic [rls_pkg::CV_W-1:0]       hist_next [MAX_DELAY];
    rls_pkg::stage1_t               s1_reg;
    rls_pkg::stage1_t               s1_next;

    logic [rls_pkg::LEN_CMP_W-1:0]     len;
    logic [LIDX_W-1:0]                 last_idx;
    logic [rls_pkg::FACTOR_PROD_W-1:0] factor_prod;
    logic [rls_pkg::FACTOR_W-1:0]      factor;
    logic                              flip;
    logic                              front;
    logic [rls_pkg::TAPS_W-1:0]        win;
    logic [rls_pkg::CV_W-1:0]          cv;
    logic [rls_pkg::DLY_CMP_W-1:0]     dly;
    logic [HIDX_W-1:0]                 hidx;
    logic [rls_pkg::SUM_W-1:0]         sum;

    always_comb
    begin
        len = {1'b0, cfg.length_in_use};
        if (len < rls_pkg::MIN_LENGTH)
        begin
            len = rls_pkg::MIN_LENGTH;
        end
        if (len > rls_pkg::LEN_CMP_W'(MAX_LENGTH))
        begin
            len = rls_pkg::LEN_CMP_W'(MAX_LENGTH);
        end
        last_idx = LIDX_W'(len - 1'b1);

        factor_prod = rls_pkg::FACTOR_PROD_W'(item.control_level)
                    * rls_pkg::FACTOR_PROD_W'(rls_pkg::FACTOR_RECIP);
        if (item.control_level < rls_pkg::BAND_LOW || item.control_level > rls_pkg::BAND_HIGH)
        begin
            factor = factor_prod[rls_pkg::FACTOR_SHIFT +: rls_pkg::FACTOR_W];
        end
        else
        begin
            factor = rls_pkg::FACTOR_MID;
        end

        if (factor == '0)
        begin
            flip = 1'b0;
        end
        else if (factor == rls_pkg::FACTOR_ALWAYS)
        begin
            flip = 1'b1;
        end
        else
        begin
            flip = item.random_draw <= factor;
        end

        front = loop_reg[last_idx] ^ flip;

        // rotate the looping part, keep the rest
        loop_next    = loop_reg;
        loop_next[0] = front;
        for (int i = 1; i < MAX_LENGTH; i++)
        begin
            if (rls_pkg::LEN_CMP_W'(i) < len)
            begin
                loop_next[i] = loop_reg[i-1];
            end
        end

        win = '0;
        for (int i = 0; i < TAP_N; i++)
        begin
            win[i] = (rls_pkg::LEN_CMP_W'(i) < len) & loop_next[i];
        end

        for (int i = 0; i < rls_pkg::CV_W; i++)
        begin
            cv[rls_pkg::CV_W-1-i] = win[i];
        end

        hist_next[0] = cv;
        for (int i = 1; i < MAX_DELAY; i++)
        begin
            hist_next[i] = hist_reg[i-1];
        end

        dly = {1'b0, cfg.delay_ticks};
        if (dly > rls_pkg::DLY_CMP_W'(MAX_DELAY))
        begin
            dly = rls_pkg::DLY_CMP_W'(MAX_DELAY);
        end
        hidx = HIDX_W'(dly - 1'b1);

        sum = '0;
        for (int i = 0; i < rls_pkg::STEPS; i++)
        begin
            if (win[i])
            begin
                sum = sum + rls_pkg::SUM_W'(item.step_level[i]);
            end
        end

        s1_next          = s1_reg;
        s1_next.cv_value = cv;
        if (!cfg.delay_enable)
        begin
            s1_next.delayed_cv = '0;
        end
        else if (dly == '0)
        begin
            s1_next.delayed_cv = cv;
        end
        else
        begin
            s1_next.delayed_cv = hist_reg[hidx];
        end
        s1_next.step_bits = win[rls_pkg::STEPS-1:0];

        // hold each trigger and gate output unless at least two of its taps are set
        if (rls_pkg::multi_tap(cfg.or_trigger_taps))
        begin
            s1_next.trig_any = |(cfg.or_trigger_taps & win);
        end
        if (rls_pkg::multi_tap(cfg.and_trigger_taps))
        begin
            s1_next.trig_all = &(~cfg.and_trigger_taps | win);
        end
        if (rls_pkg::multi_tap(cfg.or_gate_taps))
        begin
            s1_next.gate_any = |(cfg.or_gate_taps & win);
        end
        if (rls_pkg::multi_tap(cfg.and_gate_taps))
        begin
            s1_next.gate_all = &(~cfg.and_gate_taps | win);
        end

        s1_next.seq_sum     = sum;
        s1_next.scale_level = item.scale_level;
        unique case (cfg.sequencer_mode)
            rls_pkg::SEQ_SUM:
            begin
                s1_next.seq_en     = 1'b1;
                s1_next.seq_scaled = 1'b0;
            end
            rls_pkg::SEQ_SCALED:
            begin
                s1_next.seq_en     = 1'b1;
                s1_next.seq_scaled = 1'b1;
            end
            default:
            begin
                s1_next.seq_en     = 1'b0;
                s1_next.seq_scaled = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg <= '0;
            for (int i = 0; i < MAX_DELAY; i++)
            begin
                hist_reg[i] <= '0;
            end
            s1_reg <= '0;
        end
        else if (ctl.ld1)
        begin
            loop_reg <= loop_next;
            for (int i = 0; i < MAX_DELAY; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ----- src/rls_seq_scale.sv -----
// Sequencer scaling pipeline (stages 2 to 4) and the result register.
// Depends on rls_pkg; fed by rls_shift_core.
module rls_seq_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  rls_pkg::pipe_ctl_t  ctl,
    input  rls_pkg::stage1_t    s1,
    output rls_pkg::out_item_t  result
);

    rls_pkg::stage1_t              s2_info_reg;
    logic [rls_pkg::SEQ_W-1:0]     s2_q1_reg;
    rls_pkg::stage1_t              s3_info_reg;
    logic [rls_pkg::SEQ_W-1:0]     s3_q1_reg;
    logic [rls_pkg::P_W-1:0]       s3_p_reg;
    rls_pkg::out_item_t            out_reg;
    rls_pkg::out_item_t            out_next;

    logic [rls_pkg::Q1_PROD_W-1:0] q1_prod;
    logic [rls_pkg::P_W-1:0]       p_next;
    logic [rls_pkg::Q2_PROD_W-1:0] q2_prod;

    always_comb
    begin
        q1_prod = rls_pkg::Q1_PROD_W'(s1.seq_sum) * rls_pkg::Q1_PROD_W'(rls_pkg::Q1_RECIP);
        p_next  = rls_pkg::P_W'(s2_q1_reg) * rls_pkg::P_W'(s2_info_reg.scale_level);
        q2_prod = rls_pkg::Q2_PROD_W'(s3_p_reg[rls_pkg::P_W-1:2])
                * rls_pkg::Q2_PROD_W'(rls_pkg::Q2_RECIP);

        out_next                 = out_reg;
        out_next.cv_value        = s3_info_reg.cv_value;
        out_next.delayed_cv      = s3_info_reg.delayed_cv;
        out_next.step_bits       = s3_info_reg.step_bits;
        out_next.or_trigger_out  = s3_info_reg.trig_any;
        out_next.and_trigger_out = s3_info_reg.trig_all;
        out_next.or_gate_out     = s3_info_reg.gate_any;
        out_next.and_gate_out    = s3_info_reg.gate_all;
        if (s3_info_reg.seq_en)
        begin
            if (s3_info_reg.seq_scaled)
            begin
                out_next.sequencer_cv = q2_prod[rls_pkg::Q2_SHIFT +: rls_pkg::SEQ_W];
            end
            else
            begin
                out_next.sequencer_cv = s3_q1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            s2_info_reg <= s1;
            s2_q1_reg   <= q1_prod[rls_pkg::Q1_SHIFT +: rls_pkg::SEQ_W];
        end
        if (ctl.ld3)
        begin
            s3_info_reg <= s2_info_reg;
            s3_q1_reg   <= s2_q1_reg;
            s3_p_reg    <= p_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (ctl.ld4)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

// ----- src/random_looping_shift_register.sv -----
// Top level of the random looping shift register: ports, configuration
// registers, input register and stage valids. Uses rls_pkg, rls_shift_core
// and rls_seq_scale.
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata: one tick request
//  m_*       out        m_tvalid / m_tready    m_tdata: one result per tick
//  cfg_*     in         cfg_we                 cfg_index, cfg_data
//
// One request per cycle sustained while m_tready is high. The rate is set by
// the loop register, which shifts and flips in the same cycle.
// Reset loads the register defaults and clears loop bits, CV history and
// held outputs at once. With m_tready low the result holds, the stages behind
// it fill bubbles, and s_tready drops once all five stages are full.
module random_looping_shift_register #(
    parameter int MAX_LENGTH = rls_pkg::DEF_MAX_LENGTH,
    parameter int MAX_DELAY  = rls_pkg::DEF_MAX_DELAY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // control_level, random_draw, scale_level, step_level_0 .. step_level_7
    input  logic [rls_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cv_value, delayed_cv, step_bits, or_trigger_out, and_trigger_out,
    // or_gate_out, and_gate_out, sequencer_cv
    output logic [rls_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rls_pkg::cfg_t       cfg_reg;
    rls_pkg::cfg_t       cfg_next;
    rls_pkg::in_item_t   in_item;
    rls_pkg::in_item_t   s0_reg;
    rls_pkg::pipe_ctl_t  ctl;
    rls_pkg::stage1_t    s1;
    rls_pkg::out_item_t  result;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld0;

    always_comb
    begin
        in_item.control_level = s_tdata[11:0];
        in_item.random_draw   = s_tdata[18:12];
        in_item.scale_level   = s_tdata[30:19];
        for (int i = 0; i < rls_pkg::STEPS; i++)
        begin
            in_item.step_level[i] = s_tdata[31 + i*rls_pkg::LEVEL_W +: rls_pkg::LEVEL_W];
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rls_pkg::REG_LENGTH:       cfg_next.length_in_use    = cfg_data[7:0];
                rls_pkg::REG_DELAY_ENABLE: cfg_next.delay_enable     = cfg_data[0];
                rls_pkg::REG_DELAY_TICKS:  cfg_next.delay_ticks      = cfg_data[5:0];
                rls_pkg::REG_OR_TRIGGER:   cfg_next.or_trigger_taps  = cfg_data;
                rls_pkg::REG_AND_TRIGGER:  cfg_next.and_trigger_taps = cfg_data;
                rls_pkg::REG_OR_GATE:      cfg_next.or_gate_taps     = cfg_data;
                rls_pkg::REG_AND_GATE:     cfg_next.and_gate_taps    = cfg_data;
                rls_pkg::REG_SEQ_MODE:     cfg_next.sequencer_mode   = cfg_data[1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        ctl.ld4  = v3_reg && (!v4_reg || m_tready);
        ctl.ld3  = v2_reg && (!v3_reg || ctl.ld4);
        ctl.ld2  = v1_reg && (!v2_reg || ctl.ld3);
        ctl.ld1  = v0_reg && (!v1_reg || ctl.ld2);
        s_tready = !v0_reg || ctl.ld1;
        ld0      = s_tvalid && s_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                  <= '0;
            cfg_reg.length_in_use    <= rls_pkg::RESET_LENGTH;
            cfg_reg.delay_ticks      <= rls_pkg::RESET_TICKS;
            v0_reg                   <= 1'b0;
            v1_reg                   <= 1'b0;
            v2_reg                   <= 1'b0;
            v3_reg                   <= 1'b0;
            v4_reg                   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (ld0)
            begin
                v0_reg <= 1'b1;
            end
            else if (ctl.ld1)
            begin
                v0_reg <= 1'b0;
            end
            if (ctl.ld1)
            begin
                v1_reg <= 1'b1;
            end
            else if (ctl.ld2)
            begin
                v1_reg <= 1'b0;
            end
            if (ctl.ld2)
            begin
                v2_reg <= 1'b1;
            end
            else if (ctl.ld3)
            begin
                v2_reg <= 1'b0;
            end
            if (ctl.ld3)
            begin
                v3_reg <= 1'b1;
            end
            else if (ctl.ld4)
            begin
                v3_reg <= 1'b0;
            end
            if (ctl.ld4)
            begin
                v4_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                v4_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            s0_reg <= in_item;
        end
    end

    rls_shift_core #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_DELAY  (MAX_DELAY)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cfg   (cfg_reg),
        .item  (s0_reg),
        .s1    (s1)
    );

    rls_seq_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .s1     (s1),
        .result (result)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {4'b0000,
                       result.sequencer_cv,
                       result.and_gate_out,
                       result.or_gate_out,
                       result.and_trigger_out,
                       result.or_trigger_out,
                       result.step_bits,
                       result.delayed_cv,
                       result.cv_value};

endmodule

// ----- tb/sv/random_looping_shift_register_tb.sv -----
// Testbench for random_looping_shift_register: drives tick requests and
// configuration writes, predicts every result and checks it field by field.
// Depends on rls_pkg and the random_looping_shift_register RTL only.
`timescale 1ns / 100ps

module random_looping_shift_register_tb;

    localparam int LOOP_DEPTH  = rls_pkg::DEF_MAX_LENGTH;
    localparam int HIST_DEPTH  = rls_pkg::DEF_MAX_DELAY + 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic [rls_pkg::LEVEL_W-1:0]                     control_level;
        logic [rls_pkg::DRAW_W-1:0]                      random_draw;
        logic [rls_pkg::LEVEL_W-1:0]                     scale_level;
        logic [rls_pkg::STEPS-1:0][rls_pkg::LEVEL_W-1:0] step_level;
    } tick_req_t;

    typedef struct packed {
        logic [rls_pkg::CV_W-1:0]  cv_value;
        logic [rls_pkg::CV_W-1:0]  delayed_cv;
        logic [rls_pkg::STEPS-1:0] step_bits;
        logic                      or_trigger_out;
        logic                      and_trigger_out;
        logic                      or_gate_out;
        logic                      and_gate_out;
        logic [rls_pkg::SEQ_W-1:0] sequencer_cv;
    } tick_result_t;

    class loop_scoreboard;
        bit                        loop_q [LOOP_DEPTH];
        logic [rls_pkg::CV_W-1:0]  cv_hist [HIST_DEPTH];
        bit                        held_or_trig, held_and_trig, held_or_gate, held_and_gate;
        logic [rls_pkg::SEQ_W-1:0] held_seq;

        int unsigned                length_reg;
        bit                         delay_on;
        int unsigned                delay_reg;
        bit [rls_pkg::TAPS_W-1:0]   or_trig_mask, and_trig_mask, or_gate_mask, and_gate_mask;
        logic [1:0]                 seq_mode;

        tick_result_t    want_results[$];
        int              errors;

        function new();
            foreach (loop_q[i]) loop_q[i] = 1'b0;
            foreach (cv_hist[i]) cv_hist[i] = '0;
            held_or_trig  = 1'b0;
            held_and_trig = 1'b0;
            held_or_gate  = 1'b0;
            held_and_gate = 1'b0;
            held_seq      = '0;
            length_reg    = rls_pkg::RESET_LENGTH;
            delay_on      = 1'b0;
            delay_reg     = rls_pkg::RESET_TICKS;
            or_trig_mask  = '0;
            and_trig_mask = '0;
            or_gate_mask  = '0;
            and_gate_mask = '0;
            seq_mode      = rls_pkg::SEQ_OFF;
            errors        = 0;
        endfunction

        function void set_reg(logic [rls_pkg::CFG_IDX_W-1:0] idx,
                              logic [rls_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                rls_pkg::REG_LENGTH:       length_reg    = val[rls_pkg::LEN_W-1:0];
                rls_pkg::REG_DELAY_ENABLE: delay_on      = val[0];
                rls_pkg::REG_DELAY_TICKS:  delay_reg     = val[rls_pkg::TICKS_W-1:0];
                rls_pkg::REG_OR_TRIGGER:   or_trig_mask  = val;
                rls_pkg::REG_AND_TRIGGER:  and_trig_mask = val;
                rls_pkg::REG_OR_GATE:      or_gate_mask  = val;
                rls_pkg::REG_AND_GATE:     and_gate_mask = val;
                rls_pkg::REG_SEQ_MODE:     seq_mode      = val[1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return want_results.size();
        endfunction

        function bit bit_at(int unsigned pos, int unsigned len);
            return (pos < len) ? loop_q[pos] : 1'b0;
        endfunction

        function bit eval_taps(bit [rls_pkg::TAPS_W-1:0] mask, bit want_and,
                               int unsigned len, bit held);
            bit v;
            if ($countones(mask) < 2) return held;
            v = want_and;
            for (int i = 0; i < rls_pkg::TAPS_W; i++)
                if (mask[i]) v = want_and ? (v & bit_at(i, len)) : (v | bit_at(i, len));
            return v;
        endfunction

        function void predict_tick(tick_req_t t);
            int unsigned              len, factor, dly, seq;
            bit                       flip, front;
            logic [rls_pkg::CV_W-1:0] cv;
            tick_result_t             r;
            len = (length_reg < 8) ? 8 : ((length_reg > LOOP_DEPTH) ? LOOP_DEPTH : length_reg);
            if (t.control_level >= rls_pkg::BAND_LOW && t.control_level <= rls_pkg::BAND_HIGH)
                factor = 50;
            else
                factor = (int'(t.control_level) * 50) / 1700;
            if (factor == 0)
                flip = 1'b0;
            else if (factor == 100)
                flip = 1'b1;
            else
                flip = (int'(t.random_draw) <= factor);

            front = loop_q[len-1] ^ flip;
            for (int unsigned i = len - 1; i > 0; i--) loop_q[i] = loop_q[i-1];
            loop_q[0] = front;

            cv = '0;
            for (int i = 0; i < rls_pkg::CV_W; i++)
                cv = {cv[rls_pkg::CV_W-2:0], bit_at(i, len)};
            for (int i = HIST_DEPTH - 1; i > 0; i--) cv_hist[i] = cv_hist[i-1];
            cv_hist[0] = cv;
            dly = (delay_reg > rls_pkg::DEF_MAX_DELAY) ? rls_pkg::DEF_MAX_DELAY : delay_reg;

            held_or_trig  = eval_taps(or_trig_mask, 1'b0, len, held_or_trig);
            held_and_trig = eval_taps(and_trig_mask, 1'b1, len, held_and_trig);
            held_or_gate  = eval_taps(or_gate_mask, 1'b0, len, held_or_gate);
            held_and_gate = eval_taps(and_gate_mask, 1'b1, len, held_and_gate);

            if (seq_mode == rls_pkg::SEQ_SUM || seq_mode == rls_pkg::SEQ_SCALED)
            begin
                seq = 0;
                for (int i = 0; i < rls_pkg::STEPS; i++)
                    if (bit_at(i, len)) seq += int'(t.step_level[i]);
                seq = (seq * 4096) / 3500;
                if (seq_mode == rls_pkg::SEQ_SCALED) seq = (seq * int'(t.scale_level)) / 3500;
                held_seq = seq[rls_pkg::SEQ_W-1:0];
            end

            r.cv_value   = cv;
            r.delayed_cv = delay_on ? cv_hist[dly] : '0;
            for (int i = 0; i < rls_pkg::STEPS; i++) r.step_bits[i] = bit_at(i, len);
            r.or_trigger_out  = held_or_trig;
            r.and_trigger_out = held_and_trig;
            r.or_gate_out     = held_or_gate;
            r.and_gate_out    = held_and_gate;
            r.sequencer_cv    = held_seq;
            want_results.insert(want_results.size(), r);
        endfunction

        function void compare(string name, logic [rls_pkg::SEQ_W-1:0] want,
                              logic [rls_pkg::SEQ_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [rls_pkg::OUT_TDATA_W-1:0] d);
            tick_result_t w;
            if (want_results.size() == 0)
            begin
                $error("result with no request pending: %h", d);
                errors++;
                return;
            end
            w = want_results.pop_front();
            compare("cv_value", w.cv_value, d[11:0]);
            compare("delayed_cv", w.delayed_cv, d[23:12]);
            compare("step_bits", w.step_bits, d[31:24]);
            compare("or_trigger_out", w.or_trigger_out, d[32]);
            compare("and_trigger_out", w.and_trigger_out, d[33]);
            compare("or_gate_out", w.or_gate_out, d[34]);
            compare("and_gate_out", w.and_gate_out, d[35]);
            compare("sequencer_cv", w.sequencer_cv, d[51:36]);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rls_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rls_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_we;
    logic [rls_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data;

    loop_scoreboard sb;
    bit             idle_on;
    int             cycles;
    int             ready_hold;

    random_looping_shift_register u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Receiver: random stall bursts while idling is on.
    initial
    begin
        m_tready   = 1'b0;
        ready_hold = 0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                ready_hold--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                ready_hold = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic tick_req_t make_tick(int unsigned level, int unsigned draw,
                                            int unsigned scale, int unsigned step);
        tick_req_t t;
        t.control_level = rls_pkg::LEVEL_W'(level);
        t.random_draw   = rls_pkg::DRAW_W'(draw);
        t.scale_level   = rls_pkg::LEVEL_W'(scale);
        for (int i = 0; i < rls_pkg::STEPS; i++) t.step_level[i] = rls_pkg::LEVEL_W'(step);
        return t;
    endfunction

    function automatic tick_req_t random_tick();
        tick_req_t t;
        case ($urandom_range(0, 3))
            0: t.control_level = rls_pkg::LEVEL_W'($urandom_range(0, 4095));
            1: t.control_level = rls_pkg::LEVEL_W'($urandom_range(1690, 1810));
            2: t.control_level = rls_pkg::LEVEL_W'($urandom_range(0, 120));
            default: t.control_level = rls_pkg::LEVEL_W'($urandom_range(3380, 4095));
        endcase
        t.random_draw = rls_pkg::DRAW_W'($urandom_range(0, 99));
        t.scale_level = rls_pkg::LEVEL_W'($urandom_range(0, 4095));
        for (int i = 0; i < rls_pkg::STEPS; i++)
            t.step_level[i] = rls_pkg::LEVEL_W'($urandom_range(0, 4095));
        return t;
    endfunction

    function automatic logic [rls_pkg::TAPS_W-1:0] random_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'h1 << $urandom_range(0, 15);
            2: return (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
            3: return 16'hFFFF;
            default: return rls_pkg::TAPS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back requests.
    task automatic send_tick(tick_req_t t);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, t.step_level, t.scale_level, t.random_draw, t.control_level};
        do @(posedge clk); while (!s_tready);
        sb.predict_tick(t);
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
    endtask

    task automatic write_reg(logic [rls_pkg::CFG_IDX_W-1:0] idx,
                             logic [rls_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(int unsigned len, bit en, int unsigned ticks,
                             logic [rls_pkg::TAPS_W-1:0] ot, logic [rls_pkg::TAPS_W-1:0] at,
                             logic [rls_pkg::TAPS_W-1:0] og, logic [rls_pkg::TAPS_W-1:0] ag,
                             logic [1:0] mode);
        write_reg(rls_pkg::REG_LENGTH, rls_pkg::CFG_DATA_W'(len));
        write_reg(rls_pkg::REG_DELAY_ENABLE, rls_pkg::CFG_DATA_W'(en));
        write_reg(rls_pkg::REG_DELAY_TICKS, rls_pkg::CFG_DATA_W'(ticks));
        write_reg(rls_pkg::REG_OR_TRIGGER, ot);
        write_reg(rls_pkg::REG_AND_TRIGGER, at);
        write_reg(rls_pkg::REG_OR_GATE, og);
        write_reg(rls_pkg::REG_AND_GATE, ag);
        write_reg(rls_pkg::REG_SEQ_MODE, rls_pkg::CFG_DATA_W'(mode));
    endtask

    task automatic configure_random();
        int unsigned len;
        case ($urandom_range(0, 5))
            0: len = 8;
            1: len = LOOP_DEPTH;
            2: len = $urandom_range(0, 7);
            3: len = $urandom_range(129, 255);
            default: len = $urandom_range(9, 127);
        endcase
        configure(len, 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? rls_pkg::DEF_MAX_DELAY : $urandom_range(0, 63),
                  random_mask(), random_mask(), random_mask(), random_mask(),
                  2'($urandom_range(0, 3)));
    endtask

    task automatic run_random(int n);
        repeat (n) send_tick(random_tick());
        drain();
    endtask

    task automatic run_directed();
        int unsigned levels [12] = '{4095, 3400, 0, 1700, 1800, 1699, 1801, 1, 34,
                                     3399, 3433, 2047};
        int unsigned draws  [12] = '{0, 99, 0, 50, 51, 49, 52, 0, 1, 99, 0, 64};
        for (int i = 0; i < 12; i++)
            send_tick(make_tick(levels[i], draws[i], (i % 2) ? 0 : 4095,
                                (i % 2) ? 0 : 4095));
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        cycles    = 0;
        sb        = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        configure(12, 1'b1, 40, 16'hFC00, 16'h0C03, 16'h0101, 16'h0006, rls_pkg::SEQ_SUM);
        run_directed();

        configure(255, 1'b1, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  rls_pkg::SEQ_SCALED);
        run_random(50);
        configure(0, 1'b0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, rls_pkg::SEQ_OFF);
        run_random(40);

        for (int p = 0; p < 8; p++)
        begin
            idle_on = (p % 3 != 2);
            configure_random();
            run_random(50);
        end

        idle_on = 1'b0;
        configure_random();
        run_random(40);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rls_pkg.sv
src/rls_shift_core.sv
src/rls_seq_scale.sv
src/random_looping_shift_register.sv
tb/sv/random_looping_shift_register_tb.sv
